### rtl/mxf_pkg.sv
// Shared types and constants of the multichannel XOR-checked frame receiver.
package mxf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CHAN_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MASK   = 2'd2;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h26;
  localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h2A;
  localparam logic [BYTE_W-1:0] CHECK_MASK_RESET   = 8'h80;

  typedef enum logic [STATUS_W-1:0] {
    ST_BYTE     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_DATA  = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic frame_ok;
    logic read_done;
  } dp_status_t;

endpackage

### rtl/mxf_rx_if.sv
// Input channel: channel-tagged received bytes.
interface mxf_rx_if;
  import mxf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output channel, output rx_byte, input ready);
  modport sink   (input valid, input channel, input rx_byte, output ready);
endinterface

### rtl/mxf_tx_if.sv
// Output channel: frame bytes and error results.
interface mxf_tx_if;
  import mxf_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   out_channel;
  logic [BYTE_W-1:0]   frame_byte;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output out_channel, output frame_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input out_channel, input frame_byte, input status,
                  input last, output ready);
endinterface

### rtl/mxf_ctrl.sv
// Controller state machine: input acceptance and frame readout sequencing.
module mxf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  mxf_pkg::dp_status_t  st,
  output mxf_pkg::ctl_cmd_t    cmd
);
  import mxf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd.accept = (state == S_IDLE) && st.out_free;
    cmd.fetch  = (state == S_FETCH);
    cmd.emit   = (state == S_EMIT) && st.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (st.in_valid && st.out_free && st.frame_ok) state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) state_next = st.read_done ? S_IDLE : S_FETCH;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/mxf_datapath.sv
// Datapath: configuration, per-channel parser state, frame memory and result register.
module mxf_datapath #(
  parameter int CHANNELS    = 4,
  parameter int FRAME_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  mxf_rx_if.sink                        rx,
  mxf_tx_if.source                      tx,
  input  logic                          cfg_we,
  input  logic [mxf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mxf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mxf_pkg::ctl_cmd_t             cmd,
  output mxf_pkg::dp_status_t           st
);
  import mxf_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOTS = 2 ** CH_W;
  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int DEPTH = SLOTS * (2 ** POS_W);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_BYTES);

  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] end_marker;
  logic [BYTE_W-1:0] check_mask;

  phase_t            phase [SLOTS];
  logic [CNT_W-1:0]  fill  [SLOTS];
  logic [BYTE_W-1:0] chk   [SLOTS];
  logic [BYTE_W-1:0] mem   [DEPTH];

  logic [CH_W-1:0]   ch_idx;
  logic              ch_ok;
  logic              fire;
  phase_t            cur_phase;
  logic [CNT_W-1:0]  cur_fill;
  logic [BYTE_W-1:0] cur_chk;
  phase_t            phase_next;
  logic [CNT_W-1:0]  fill_next;
  logic [BYTE_W-1:0] chk_next;
  logic              mem_we;
  logic [CH_W+POS_W-1:0] mem_waddr;
  logic              err_load;
  status_t           err_code;
  logic              frame_ok;

  logic [CHAN_W-1:0] rd_ch;
  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  rd_pos;
  logic [BYTE_W-1:0] rd_data;
  logic              read_done;

  logic                out_valid;
  logic [CHAN_W-1:0]   out_ch;
  logic [BYTE_W-1:0]   out_byte;
  status_t             out_status;
  logic                out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
      check_mask   <= CHECK_MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_MARKER: start_marker <= cfg_data[BYTE_W-1:0];
        REG_END_MARKER:   end_marker   <= cfg_data[BYTE_W-1:0];
        REG_CHECK_MASK:   check_mask   <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign ch_idx    = CH_W'(rx.channel);
  assign ch_ok     = int'(rx.channel) < CHANNELS;
  assign fire      = cmd.accept && rx.valid;
  assign cur_phase = phase[ch_idx];
  assign cur_fill  = fill[ch_idx];
  assign cur_chk   = chk[ch_idx];

  // Next parser state of the addressed channel for the byte on the input.
  always_comb begin
    phase_next = cur_phase;
    fill_next  = cur_fill;
    chk_next   = cur_chk;
    mem_we     = 1'b0;
    mem_waddr  = {ch_idx, cur_fill[POS_W-1:0]};
    err_load   = 1'b0;
    err_code   = ST_MISMATCH;
    frame_ok   = 1'b0;
    if (ch_ok) begin
      unique case (cur_phase)
        PH_DATA: begin
          if (cur_fill >= FULL) begin
            phase_next = PH_HUNT;
            fill_next  = '0;
            err_load   = 1'b1;
            err_code   = ST_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            fill_next = cur_fill + 1'b1;
            if (rx.rx_byte == end_marker) begin
              phase_next = PH_CHECK;
            end else begin
              chk_next = cur_chk ^ rx.rx_byte;
            end
          end
        end
        PH_CHECK: begin
          phase_next = PH_HUNT;
          fill_next  = '0;
          if ((cur_chk | check_mask) == rx.rx_byte) begin
            frame_ok = 1'b1;
          end else begin
            err_load = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (rx.rx_byte == start_marker) begin
            mem_we     = 1'b1;
            mem_waddr  = {ch_idx, {POS_W{1'b0}}};
            fill_next  = CNT_W'(1);
            chk_next   = rx.rx_byte;
            phase_next = PH_DATA;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase[i] <= PH_HUNT;
        fill[i]  <= '0;
        chk[i]   <= '0;
      end
    end else if (fire && ch_ok) begin
      phase[ch_idx] <= phase_next;
      fill[ch_idx]  <= fill_next;
      chk[ch_idx]   <= chk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && mem_we) mem[mem_waddr] <= rx.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) rd_data <= mem[{CH_W'(rd_ch), rd_pos[POS_W-1:0]}];
  end

  // Readout bookkeeping: the frame stays in memory until the channel refills it.
  always_ff @(posedge clk) begin
    if (fire && frame_ok) begin
      rd_ch  <= rx.channel;
      rd_cnt <= (cur_fill > FULL) ? FULL : cur_fill;
      rd_pos <= '0;
    end else if (cmd.emit) begin
      rd_pos <= rd_pos + 1'b1;
    end
  end

  assign read_done = (CNT_W'(rd_pos + 1'b1) == rd_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || (fire && err_load)) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch     <= rd_ch;
      out_byte   <= rd_data;
      out_status <= ST_BYTE;
      out_last   <= read_done;
    end else if (fire && err_load) begin
      out_ch     <= rx.channel;
      out_byte   <= '0;
      out_status <= err_code;
      out_last   <= 1'b1;
    end
  end

  assign rx.ready       = cmd.accept;
  assign tx.valid       = out_valid;
  assign tx.out_channel = out_ch;
  assign tx.frame_byte  = out_byte;
  assign tx.status      = out_status;
  assign tx.last        = out_last;

  assign st.in_valid  = rx.valid;
  assign st.out_free  = !out_valid || tx.ready;
  assign st.frame_ok  = frame_ok;
  assign st.read_done = read_done;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ch_ok |-> cur_fill <= FULL)
    else $error("channel fill count beyond frame size");

  a_check_fill: assert property (@(posedge clk) disable iff (rst)
    ch_ok && cur_phase == PH_CHECK |-> cur_fill >= CNT_W'(2))
    else $error("awaiting check with fewer than two stored bytes");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_BYTE |-> out_last && out_byte == '0)
    else $error("error result without last flag or with nonzero byte");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> rd_pos < rd_cnt)
    else $error("readout position past frame length");

endmodule

### rtl/multichannel_xor_checked_frame_receiver.sv
// Top level of the multichannel XOR-checked frame receiver.
//
// Usage: bytes tagged with a channel number enter on rx (valid/ready). Each
// channel hunts for the start marker, stores the frame up to and including
// the end marker, and compares the following byte with the XOR check ORed
// with check_mask. A matching frame is sent on tx byte by byte, last set on
// its final byte; a mismatch or an overflowing frame gives one error item
// with last set. Bytes on channels at or above CHANNELS are dropped.
// Configuration: cfg_we/cfg_index/cfg_data write start_marker (0),
// end_marker (1) and check_mask (2); the user must write them only while the
// block is idle, which the block itself does not enforce. An error item is on
// tx in the cycle after the byte that causes it; the first byte of a good
// frame is read from memory in state FETCH and loaded into the output
// register in state EMIT. Throughput: one item per cycle while no frame is
// read out and tx is not stalled; rx is held off during a frame readout.
// Stalls: while tx is stalled with a result waiting, rx is not ready.
// Reset: rst (synchronous) returns all channels to hunting and restores the
// default markers and mask; the frame memory needs no clearing.
module multichannel_xor_checked_frame_receiver #(
  parameter int CHANNELS    = 4,
  parameter int FRAME_BYTES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  mxf_rx_if.sink                         rx,
  mxf_tx_if.source                       tx,
  input  logic                           cfg_we,
  input  logic [mxf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mxf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mxf_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  mxf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  mxf_datapath #(
    .CHANNELS    (CHANNELS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .tx        (tx),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
